@@ rtl/core/tcw_pkg.sv @@
package tcw_pkg;

   // character codes with special handling
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   // cell buffer interface widths
   localparam int ADDR_WIDTH = 11;
   localparam int CHAR_WIDTH = 8;
   localparam int ATTR_WIDTH = 8;
   localparam int WORD_WIDTH = ATTR_WIDTH + CHAR_WIDTH;

   localparam logic [ATTR_WIDTH-1:0] ATTR_RESET = 8'd7;

   // controller to datapath
   typedef struct packed {
      logic newline;   // move cursor to start of next row, no write
      logic load;      // build a cell word at the cursor and advance
      logic space;     // word is a tab space; last at a tab stop or a column wrap
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_newline;  // incoming character is a newline
      logic in_tab;      // incoming character is a tab
      logic out_last;    // held word is the final one of this character
   } status_type;

endpackage

@@ rtl/core/tcw_ctrl.sv @@
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_WRITE = 1'b1;

   logic state_ff;
   logic state_in;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (status.in_newline) begin
                  cmd.newline = 1'b1;
               end else begin
                  cmd.load  = 1'b1;
                  cmd.space = status.in_tab;
                  state_in  = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // next space of a tab
                  cmd.load  = 1'b1;
                  cmd.space = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/tcw_datapath.sv @@
module tcw_datapath #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int TAB_STOP       = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tcw_pkg::CHAR_WIDTH-1:0]      req_char_code,
   input  logic                                csr_write,
   input  logic [tcw_pkg::ATTR_WIDTH-1:0]      csr_text_attribute,
   input  tcw_pkg::cmd_type                    cmd,
   output tcw_pkg::status_type                 status,
   output logic [tcw_pkg::ADDR_WIDTH-1:0]      rsp_cell_address,
   output logic [tcw_pkg::WORD_WIDTH-1:0]      rsp_cell_word,
   output logic                                rsp_last_write
);

   localparam int COL_W  = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int BASE_W = $clog2(SCREEN_ROWS * SCREEN_COLUMNS);
   localparam int SUM_W  = (BASE_W + 1 > tcw_pkg::ADDR_WIDTH) ? BASE_W + 1
                                                              : tcw_pkg::ADDR_WIDTH;

   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(SCREEN_COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [PH_W-1:0]   PH_LAST  = PH_W'(TAB_STOP - 1);
   localparam logic [BASE_W:0]   ROW_STEP = (BASE_W + 1)'(SCREEN_COLUMNS);

   // cursor: column, row, row start address, column modulo tab stop
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [tcw_pkg::ATTR_WIDTH-1:0] attr_ff;

   // held output word
   logic [tcw_pkg::ADDR_WIDTH-1:0] addr_ff;
   logic [tcw_pkg::WORD_WIDTH-1:0] word_ff;
   logic                           last_ff;

   logic                           col_wrap;
   logic                           row_wrap;
   logic [BASE_W:0]                base_step;
   logic [SUM_W-1:0]               addr_sum;
   logic [tcw_pkg::CHAR_WIDTH-1:0] char_sel;

   assign col_wrap  = (col_ff == COL_LAST);
   assign row_wrap  = (row_ff == ROW_LAST);
   assign base_step = {1'b0, base_ff} + ROW_STEP;
   assign addr_sum  = SUM_W'(base_ff) + SUM_W'(col_ff);
   assign char_sel  = cmd.space ? tcw_pkg::CODE_SPACE : req_char_code;

   // cursor advance
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      base_in  = base_ff;
      phase_in = phase_ff;
      if (cmd.newline || (cmd.load && col_wrap)) begin
         col_in   = '0;
         phase_in = '0;
         row_in   = row_wrap ? '0 : row_ff + 1'b1;
         base_in  = row_wrap ? '0 : base_step[BASE_W-1:0];
      end else if (cmd.load) begin
         col_in   = col_ff + 1'b1;
         phase_in = (phase_ff == PH_LAST) ? '0 : phase_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         base_ff  <= '0;
         phase_ff <= '0;
         attr_ff  <= tcw_pkg::ATTR_RESET;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         base_ff  <= base_in;
         phase_ff <= phase_in;
         if (csr_write) begin
            attr_ff <= csr_text_attribute;
         end
      end
   end

   // output word capture; a tab ends at its stop or at a column wrap
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= addr_sum[tcw_pkg::ADDR_WIDTH-1:0];
         word_ff <= {attr_ff, char_sel};
         last_ff <= !cmd.space || (phase_in == '0);
      end
   end

   assign status.in_newline = (req_char_code == tcw_pkg::CODE_NEWLINE);
   assign status.in_tab     = (req_char_code == tcw_pkg::CODE_TAB);
   assign status.out_last   = last_ff;

   assign rsp_cell_address = addr_ff;
   assign rsp_cell_word    = word_ff;
   assign rsp_last_write   = last_ff;

endmodule

@@ rtl/core/text_console_cell_writer_top.sv @@
// The first cell word is valid in the cycle after a character is accepted.
// A character makes n cell writes (1 for a printable byte, up to TAB_STOP for a
//   tab, 0 for a newline); the controller holds one character at a time and
//   takes no new one until the last word of the current one is accepted.
// Reset: synchronous; cursor to row 0 column 0, text attribute to 7.
module text_console_cell_writer_top #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int TAB_STOP       = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tcw_pkg::CHAR_WIDTH-1:0] req_char_code,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tcw_pkg::ADDR_WIDTH-1:0] rsp_cell_address,
   output logic [tcw_pkg::WORD_WIDTH-1:0] rsp_cell_word,
   output logic                           rsp_last_write,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::ATTR_WIDTH-1:0] csr_text_attribute
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   // attribute register takes a word in any cycle
   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .TAB_STOP       (TAB_STOP)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_char_code      (req_char_code),
      .csr_write          (csr_valid && csr_ready),
      .csr_text_attribute (csr_text_attribute),
      .cmd                (cmd),
      .status             (status),
      .rsp_cell_address   (rsp_cell_address),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_last_write     (rsp_last_write)
   );

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int TAB_WIDTH    = 4;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [tcw_pkg::ADDR_WIDTH-1:0] address;
      logic [tcw_pkg::WORD_WIDTH-1:0] word;
      logic                           last_write;
   } cell_write_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [tcw_pkg::CHAR_WIDTH-1:0] req_char_code = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b1;
   logic [tcw_pkg::ADDR_WIDTH-1:0] rsp_cell_address;
   logic [tcw_pkg::WORD_WIDTH-1:0] rsp_cell_word;
   logic                           rsp_last_write;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tcw_pkg::ATTR_WIDTH-1:0] csr_text_attribute = '0;

   // testbench copy of the cursor and attribute
   int                             cursor_row = 0;
   int                             cursor_col = 0;
   logic [tcw_pkg::ATTR_WIDTH-1:0] text_attr = tcw_pkg::ATTR_RESET;

   logic [tcw_pkg::CHAR_WIDTH-1:0] chars_pending[$];
   cell_write_type                 cells_due[$];
   int                             chars_issued = 0;
   int                             chars_taken = 0;
   int                             mismatch_count = 0;
   int                             idle_pct = 0;
   int                             req_gap = 0;
   int                             rsp_gap = 0;
   logic                           req_taken = 1'b0;
   int                             quiet_cycles = 0;

   text_console_cell_writer_top #(
      .SCREEN_COLUMNS(COLUMNS),
      .SCREEN_ROWS   (ROWS),
      .TAB_STOP      (TAB_WIDTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_address  (rsp_cell_address),
      .rsp_cell_word     (rsp_cell_word),
      .rsp_last_write    (rsp_last_write),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_text_attribute(csr_text_attribute)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void next_row();
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= ROWS) begin
         cursor_row = 0;
      end
   endfunction

   // expected cell writes for one character; updates the cursor
   function automatic void predict_cell_writes(input logic [tcw_pkg::CHAR_WIDTH-1:0] code);
      cell_write_type                 entry;
      int                             count;
      logic [tcw_pkg::CHAR_WIDTH-1:0] glyph;
      if (code == tcw_pkg::CODE_NEWLINE) begin
         next_row();
         return;
      end
      if (code == tcw_pkg::CODE_TAB) begin
         count = TAB_WIDTH - (cursor_col % TAB_WIDTH);
         glyph = tcw_pkg::CODE_SPACE;
      end else begin
         count = 1;
         glyph = code;
      end
      for (int k = 0; k < count; k++) begin
         entry.address = tcw_pkg::ADDR_WIDTH'(cursor_row * COLUMNS + cursor_col);
         entry.word    = {text_attr, glyph};
         cursor_col++;
         if (cursor_col >= COLUMNS) begin
            next_row();
         end
         // a tab ends early when the column wraps
         entry.last_write = (k == count - 1) || (cursor_col == 0);
         cells_due.push_back(entry);
         if (cursor_col == 0) begin
            break;
         end
      end
   endfunction

   // mostly printable bytes, with newlines and tabs mixed in
   function automatic logic [tcw_pkg::CHAR_WIDTH-1:0] random_code();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         return tcw_pkg::CODE_NEWLINE;
      end else if (roll < 35) begin
         return tcw_pkg::CODE_TAB;
      end
      return tcw_pkg::CHAR_WIDTH'($urandom_range(255));
   endfunction

   function automatic logic [tcw_pkg::CHAR_WIDTH-1:0] random_glyph();
      logic [tcw_pkg::CHAR_WIDTH-1:0] code;
      do begin
         code = tcw_pkg::CHAR_WIDTH'($urandom_range(255));
      end while (code == tcw_pkg::CODE_NEWLINE || code == tcw_pkg::CODE_TAB);
      return code;
   endfunction

   function automatic void send_char(input logic [tcw_pkg::CHAR_WIDTH-1:0] code);
      chars_pending.push_back(code);
      chars_issued++;
   endfunction

   // wait until every character is taken and every word has come back
   task automatic wait_idle();
      while (chars_taken != chars_issued || cells_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_attribute(input logic [tcw_pkg::ATTR_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver: holds a word until taken, idles in bursts
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (chars_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_valid     <= 1'b1;
            req_char_code <= chars_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
            if (idle_pct > 0) begin
               req_gap <= $urandom_range(15);
            end
         end
      end
   end

   // response stall in bursts
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         rsp_gap   <= $urandom_range(15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on accepted characters, check returned words
   always @(posedge clock) begin
      cell_write_type want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            text_attr = csr_text_attribute;
         end
         if (req_valid && !req_stall) begin
            predict_cell_writes(req_char_code);
            chars_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (cells_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word addr=%0d word=%h",
                                         rsp_cell_address, rsp_cell_word));
            end else begin
               want = cells_due.pop_front();
               if (rsp_cell_address !== want.address) begin
                  report_mismatch($sformatf("cell_address got %0d want %0d",
                                            rsp_cell_address, want.address));
               end
               if (rsp_cell_word !== want.word) begin
                  report_mismatch($sformatf("cell_word got %h want %h",
                                            rsp_cell_word, want.word));
               end
               if (rsp_last_write !== want.last_write) begin
                  report_mismatch($sformatf("last_write got %b want %b",
                                            rsp_last_write, want.last_write));
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("text_console_cell_writer_top regression: fail");
         $finish;
      end
   end

   initial begin
      int rows_to_go;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, tabs at offsets 0, 2 and 3 from a stop, blank line
      idle_pct = 20;
      send_char(8'h41);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(tcw_pkg::CODE_TAB);
      send_char(tcw_pkg::CODE_TAB);
      send_char(8'h80);
      send_char(8'h7F);
      send_char(tcw_pkg::CODE_TAB);
      send_char(8'h78);
      send_char(8'h79);
      send_char(tcw_pkg::CODE_TAB);
      send_char(tcw_pkg::CODE_NEWLINE);
      send_char(tcw_pkg::CODE_NEWLINE);
      send_char(tcw_pkg::CODE_TAB);
      send_char(tcw_pkg::CODE_SPACE);
      send_char(8'h0D);
      send_char(8'h08);
      send_char(8'h01);
      send_char(8'hFE);
      send_char(8'h55);
      send_char(8'hAA);
      send_char(tcw_pkg::CODE_TAB);
      send_char(tcw_pkg::CODE_NEWLINE);
      wait_idle();

      // random mix, random attribute
      write_attribute(tcw_pkg::ATTR_WIDTH'($urandom_range(255)));
      idle_pct = 10;
      repeat (50) send_char(random_code());
      wait_idle();

      // run the cursor to the bottom right corner and wrap there
      write_attribute('0);
      idle_pct = 25;
      rows_to_go = (ROWS - 1 - cursor_row + ROWS) % ROWS;
      if (rows_to_go == 0 && cursor_col != 0) begin
         rows_to_go = ROWS;
      end
      repeat (rows_to_go) send_char(tcw_pkg::CODE_NEWLINE);
      repeat (COLUMNS - 1) send_char(random_glyph());
      send_char(tcw_pkg::CODE_TAB);
      repeat (5) send_char(random_code());
      wait_idle();

      // heavy idling on both sides
      write_attribute('1);
      idle_pct = 35;
      repeat (50) send_char(random_code());
      wait_idle();

      // closing stretch at full rate
      write_attribute(tcw_pkg::ATTR_WIDTH'($urandom_range(255)));
      idle_pct = 0;
      repeat (25) send_char(random_code());
      wait_idle();

      if (mismatch_count == 0) begin
         $display("text_console_cell_writer_top regression: pass");
      end else begin
         $display("text_console_cell_writer_top regression: fail");
      end
      $finish;
   end

endmodule
